### sv/dqsr_pkg.sv
// dqsr_pkg: shared constants, codes and controller/datapath handshake types
// for the deque with search and remove. No dependencies.
`default_nettype none

package dqsr_pkg;

   // Ring store geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int WORD_W = 64;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;
   localparam int OCNT_W = 5;

   // Opcodes (any other code behaves as query)
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
   localparam logic [OP_W-1:0] OP_QUERY      = 3'd6;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_RD_FRONT,
      S_RD_BACK,
      S_CAP_BACK,
      S_RESP
   } ctl_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic load;
      logic dispatch;
      logic scan_step;
      logic scan_commit;
      logic rd_front;
      logic rd_back;
      logic cap_back;
   } dqsr_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            scan_done;
   } dqsr_stat_type;

endpackage

`default_nettype wire

### sv/dqsr_ctrl.sv
// dqsr_ctrl: sequencer for the deque; steps dispatch, scan, front/back fetch
// and the response beat. Depends on dqsr_pkg.
`default_nettype none

module dqsr_ctrl
   import dqsr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dqsr_stat_type stat,
   output dqsr_cmd_type       cmd,
   output logic               busy,
   output logic               rsp_strobe
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            if ((stat.op == OP_CONTAINS || stat.op == OP_REMOVE) && !stat.empty) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RD_FRONT;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               cmd.scan_commit = 1'b1;
               state_in        = S_RD_FRONT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_RD_FRONT: begin
            cmd.rd_front = 1'b1;
            state_in     = S_RD_BACK;
         end
         S_RD_BACK: begin
            cmd.rd_back = 1'b1;
            state_in    = S_CAP_BACK;
         end
         S_CAP_BACK: begin
            cmd.cap_back = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/dqsr_dpath.sv
// dqsr_dpath: ring store, front/count registers, scan and compaction logic,
// result registers. Depends on dqsr_pkg.
`default_nettype none

module dqsr_dpath
   import dqsr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dqsr_cmd_type        cmd,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [WORD_W-1:0]   req_value,
   output dqsr_stat_type            stat,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic [OCNT_W-1:0]        rsp_removed_count,
   output logic [WORD_W-1:0]        rsp_popped_value,
   output logic [WORD_W-1:0]        rsp_front_value,
   output logic [WORD_W-1:0]        rsp_back_value,
   output logic [OCNT_W-1:0]        rsp_entry_count,
   output logic                     rsp_is_empty
);

   // ring position of logical offset off from the front
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [WORD_W-1:0] mem [DEPTH];

   // control state
   logic [IDX_W-1:0]  front_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  rd_i_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic              pend_ff;
   logic              pop_pend_ff;

   // payload
   logic [OP_W-1:0]   op_ff;
   logic [WORD_W-1:0] val_ff;
   logic [WORD_W-1:0] rdata_ff;
   logic [STAT_W-1:0] status_ff;
   logic              found_ff;
   logic [CNT_W-1:0]  removed_ff;
   logic [WORD_W-1:0] popped_ff;
   logic [WORD_W-1:0] front_val_ff;
   logic [WORD_W-1:0] back_val_ff;

   logic              full;
   logic              empty;
   logic [IDX_W-1:0]  front_dec;
   logic [IDX_W-1:0]  front_inc;
   logic [CNT_W-1:0]  last_off;
   logic              hit;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign last_off  = count_ff - 1'b1;
   assign hit       = (rdata_ff == val_ff);

   assign stat.op        = op_ff;
   assign stat.empty     = empty;
   assign stat.scan_done = (rd_i_ff == count_ff) && !pend_ff;

   // read address select
   always_comb begin
      rd_addr = front_ff;
      if (cmd.dispatch && op_ff == OP_POP_BACK) begin
         rd_addr = slot(front_ff, last_off);
      end else if (cmd.scan_step) begin
         rd_addr = slot(front_ff, rd_i_ff);
      end else if (cmd.rd_front) begin
         rd_addr = front_ff;
      end else if (cmd.rd_back) begin
         rd_addr = slot(front_ff, last_off);
      end
   end

   // write port: pushes, and compaction of kept words during remove
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = front_dec;
      wr_data = val_ff;
      if (cmd.dispatch && !full && op_ff == OP_PUSH_FRONT) begin
         wr_en = 1'b1;
      end else if (cmd.dispatch && !full && op_ff == OP_PUSH_BACK) begin
         wr_en   = 1'b1;
         wr_addr = slot(front_ff, count_ff);
      end else if (cmd.scan_step && pend_ff && op_ff == OP_REMOVE && !hit) begin
         wr_en   = 1'b1;
         wr_addr = slot(front_ff, kept_ff);
         wr_data = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= '0;
         count_ff    <= '0;
         rd_i_ff     <= '0;
         kept_ff     <= '0;
         pend_ff     <= 1'b0;
         pop_pend_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            pop_pend_ff <= 1'b0;
         end
         if (cmd.dispatch) begin
            rd_i_ff <= '0;
            kept_ff <= '0;
            pend_ff <= 1'b0;
            case (op_ff)
               OP_PUSH_FRONT: begin
                  if (!full) begin
                     front_ff <= front_dec;
                     count_ff <= count_ff + 1'b1;
                  end
               end
               OP_PUSH_BACK: begin
                  if (!full) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (!empty) begin
                     front_ff    <= front_inc;
                     count_ff    <= last_off;
                     pop_pend_ff <= 1'b1;
                  end
               end
               OP_POP_BACK: begin
                  if (!empty) begin
                     count_ff    <= last_off;
                     pop_pend_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.scan_step) begin
            if (rd_i_ff != count_ff) begin
               rd_i_ff <= rd_i_ff + 1'b1;
               pend_ff <= 1'b1;
            end else begin
               pend_ff <= 1'b0;
            end
            if (pend_ff && !hit) begin
               kept_ff <= kept_ff + 1'b1;
            end
         end
         if (cmd.scan_commit && op_ff == OP_REMOVE) begin
            count_ff <= kept_ff;
         end
      end
   end

   // request and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_opcode;
         val_ff     <= req_value;
         status_ff  <= STAT_OK;
         found_ff   <= 1'b0;
         removed_ff <= '0;
         popped_ff  <= '0;
      end
      if (cmd.dispatch) begin
         case (op_ff)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               if (full) begin
                  status_ff <= STAT_FULL;
               end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_CONTAINS, OP_REMOVE: begin
               if (empty) begin
                  status_ff <= STAT_EMPTY;
               end
            end
            default: ;
         endcase
      end
      if (cmd.scan_step && pend_ff && hit) begin
         if (op_ff == OP_REMOVE) begin
            removed_ff <= removed_ff + 1'b1;
         end else begin
            found_ff <= 1'b1;
         end
      end
      // popped word lands in rdata during the first fetch cycle
      if (cmd.rd_front && pop_pend_ff) begin
         popped_ff <= rdata_ff;
      end
      if (cmd.rd_back) begin
         front_val_ff <= empty ? '0 : rdata_ff;
      end
      if (cmd.cap_back) begin
         back_val_ff <= empty ? '0 : rdata_ff;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_removed_count = OCNT_W'(removed_ff);
   assign rsp_popped_value  = popped_ff;
   assign rsp_front_value   = front_val_ff;
   assign rsp_back_value    = back_val_ff;
   assign rsp_entry_count   = OCNT_W'(count_ff);
   assign rsp_is_empty      = empty;

endmodule

`default_nettype wire

### sv/deque_with_search_remove_unit.sv
// deque_with_search_remove_unit: top level of the bounded deque with search
// and remove-all. Depends on dqsr_pkg, dqsr_ctrl, dqsr_dpath.
//
//   channel   handshake              payload
//   -------   --------------------   -------------------------------------
//   request   start, busy (out)      req_opcode, req_value
//   response  rsp_strobe (out)       rsp_status .. rsp_is_empty (8 fields)
//
// Sequencing: one request beat at a time. Push, pop, query, and contains or
// remove on an empty deque step through dispatch, front fetch, back fetch,
// back capture and response; contains and remove on a non-empty deque add a
// scan, reading one ring entry per cycle through the single store read port.
// Reset: synchronous, active high; deque comes up empty, busy low.
// Ring contents have no reset; words read from dead slots never reach a response.
// Stalls: busy is high from accept through the response beat. The response
// is presented for one cycle on rsp_strobe; the receiver cannot stall it.
`default_nettype none

module deque_with_search_remove_unit
   import dqsr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [WORD_W-1:0]   req_value,
   output logic                     rsp_strobe,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_found,
   output logic [OCNT_W-1:0]        rsp_removed_count,
   output logic [WORD_W-1:0]        rsp_popped_value,
   output logic [WORD_W-1:0]        rsp_front_value,
   output logic [WORD_W-1:0]        rsp_back_value,
   output logic [OCNT_W-1:0]        rsp_entry_count,
   output logic                     rsp_is_empty
);

   dqsr_cmd_type  cmd;
   dqsr_stat_type stat;

   // sequencer: one state per phase of an operation
   dqsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // ring store, pointers, scan/compact engine and result registers
   dqsr_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_removed_count (rsp_removed_count),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   // an accepted beat keeps the unit busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // the response strobe drops right after each response beat
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("is_empty disagrees with entry_count");

   // an empty deque reports zero front and back words
   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_empty) |-> (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("nonzero front/back on empty deque");

endmodule

`default_nettype wire

### verif/deque_checker.sv
`timescale 1ns / 1ps
// deque_checker: watches the request and response channels of the deque unit,
// predicts each response and compares it field by field. Depends on dqsr_pkg.
module deque_checker
   import dqsr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [OP_W-1:0]     req_opcode,
   input  wire logic [WORD_W-1:0]   req_value,
   input  wire logic                rsp_strobe,
   input  wire logic [STAT_W-1:0]   rsp_status,
   input  wire logic                rsp_found,
   input  wire logic [OCNT_W-1:0]   rsp_removed_count,
   input  wire logic [WORD_W-1:0]   rsp_popped_value,
   input  wire logic [WORD_W-1:0]   rsp_front_value,
   input  wire logic [WORD_W-1:0]   rsp_back_value,
   input  wire logic [OCNT_W-1:0]   rsp_entry_count,
   input  wire logic                rsp_is_empty,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       checked_count,
   output int                       full_hits,
   output int                       empty_hits
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              found;
      logic [OCNT_W-1:0] removed;
      logic [WORD_W-1:0] popped;
      logic [WORD_W-1:0] front;
      logic [WORD_W-1:0] back;
      logic [OCNT_W-1:0] count;
      logic              empty;
   } deque_rsp_type;

   // shadow deque
   logic [WORD_W-1:0] ring_words [DEPTH];
   int unsigned       head_idx;
   int unsigned       live_count;

   deque_rsp_type pending_rsp [$];

   function automatic int unsigned ring_pos(input int unsigned offset);
      return (head_idx + offset) % DEPTH;
   endfunction

   function automatic deque_rsp_type apply_deque_op(input logic [OP_W-1:0] op,
                                                    input logic [WORD_W-1:0] val);
      deque_rsp_type     r;
      logic [WORD_W-1:0] kept_words [DEPTH];
      logic [WORD_W-1:0] w;
      int unsigned       kept;
      int unsigned       removed;
      r       = '0;
      kept    = 0;
      removed = 0;
      r.status = STAT_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (live_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               head_idx = (head_idx + DEPTH - 1) % DEPTH;
               ring_words[head_idx] = val;
               live_count++;
            end else begin
               ring_words[ring_pos(live_count)] = val;
               live_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_CONTAINS, OP_REMOVE: begin
            if (live_count == 0) begin
               r.status = STAT_EMPTY;
            end else if (op == OP_POP_FRONT) begin
               r.popped = ring_words[head_idx];
               head_idx = (head_idx + 1) % DEPTH;
               live_count--;
            end else if (op == OP_POP_BACK) begin
               r.popped = ring_words[ring_pos(live_count - 1)];
               live_count--;
            end else if (op == OP_CONTAINS) begin
               for (int unsigned i = 0; i < live_count; i++)
                  if (ring_words[ring_pos(i)] == val) r.found = 1'b1;
            end else begin
               // drop every match, survivors slide toward the front in order
               for (int unsigned i = 0; i < live_count; i++) begin
                  w = ring_words[ring_pos(i)];
                  if (w == val) begin
                     removed++;
                  end else begin
                     kept_words[kept] = w;
                     kept++;
                  end
               end
               for (int unsigned i = 0; i < kept; i++)
                  ring_words[ring_pos(i)] = kept_words[i];
               live_count = kept;
               r.removed  = OCNT_W'(removed);
            end
         end
         default: ; // query and the unused code
      endcase
      if (live_count != 0) begin
         r.front = ring_words[head_idx];
         r.back  = ring_words[ring_pos(live_count - 1)];
      end
      r.count = OCNT_W'(live_count);
      r.empty = (live_count == 0);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                              input logic [WORD_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      deque_rsp_type want;
      if (reset) begin
         head_idx       = 0;
         live_count     = 0;
         mismatch_count = 0;
         checked_count  = 0;
         full_hits      = 0;
         empty_hits     = 0;
         pending_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
               check_field("found", WORD_W'(want.found), WORD_W'(rsp_found));
               check_field("removed_count", WORD_W'(want.removed),
                           WORD_W'(rsp_removed_count));
               check_field("popped_value", want.popped, rsp_popped_value);
               check_field("front_value", want.front, rsp_front_value);
               check_field("back_value", want.back, rsp_back_value);
               check_field("entry_count", WORD_W'(want.count), WORD_W'(rsp_entry_count));
               check_field("is_empty", WORD_W'(want.empty), WORD_W'(rsp_is_empty));
               checked_count++;
            end
         end
         if (start && !busy) begin
            want = apply_deque_op(req_opcode, req_value);
            if (want.status == STAT_FULL) full_hits++;
            if (want.status == STAT_EMPTY) empty_hits++;
            pending_rsp.push_back(want);
         end
      end
      pending_count = pending_rsp.size();
   end

endmodule

### verif/deque_with_search_remove_unit_tb.sv
`timescale 1ns / 1ps
// deque_with_search_remove_unit_tb: drives request beats into the deque unit
// and reports the verdict. Depends on dqsr_pkg, the unit and deque_checker.
module deque_with_search_remove_unit_tb;
   import dqsr_pkg::*;

   // the one opcode the package leaves unnamed; the unit treats it as query
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   localparam int RANDOM_BEATS = 1700;
   localparam int QUIET_TAIL   = 150;      // last beats go back to back
   localparam int DRAIN_CYCLES = 40;       // quiet cycles after the last response lands
   localparam int CYCLE_LIMIT  = 500000;   // watchdog bound on the whole run

   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   // bias of the random opcode mix
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [WORD_W-1:0]   req_value = '0;

   logic                busy;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_found;
   logic [OCNT_W-1:0]   rsp_removed_count;
   logic [WORD_W-1:0]   rsp_popped_value;
   logic [WORD_W-1:0]   rsp_front_value;
   logic [WORD_W-1:0]   rsp_back_value;
   logic [OCNT_W-1:0]   rsp_entry_count;
   logic                rsp_is_empty;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int full_hits;
   int empty_hits;

   int cycle_count = 0;
   int beats_sent  = 0;

   // small pool of words so that contains and remove actually find matches
   logic [WORD_W-1:0] word_pool [4];

   deque_with_search_remove_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_removed_count (rsp_removed_count),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   deque_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_removed_count (rsp_removed_count),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .full_hits         (full_hits),
      .empty_hits        (empty_hits)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_count);
         $display("status: fail");
         $finish;
      end
   end

   // Present one beat from a falling edge and hold it until the unit takes
   // it (start high, busy low at a rising edge). Returns on the next falling
   // edge with start still high, so back-to-back beats never drop start.
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
      start      <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do @(posedge clock); while (busy);
      @(negedge clock);
      beats_sent++;
   endtask

   // Sender idle burst; payload wanders so stale fields never look valid.
   task automatic idle_gap(input int cycles);
      start      <= 1'b0;
      req_opcode <= OP_W'($urandom);
      req_value  <= {$urandom, $urandom};
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] fresh_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      if ($urandom_range(9) < 8) return word_pool[$urandom_range(3)];
      return {$urandom, $urandom};
   endfunction

   // Fill phases push hard to reach full, drain phases pop and remove down to
   // empty, even phases mix everything.
   function automatic logic [OP_W-1:0] pick_opcode(input op_mix_type mix);
      int roll;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            if (roll < 35) return OP_PUSH_FRONT;
            if (roll < 70) return OP_PUSH_BACK;
            if (roll < 78) return OP_POP_FRONT;
            if (roll < 84) return OP_POP_BACK;
            if (roll < 92) return OP_CONTAINS;
            if (roll < 96) return OP_REMOVE;
         end
         MIX_DRAIN: begin
            if (roll < 10) return OP_PUSH_FRONT;
            if (roll < 20) return OP_PUSH_BACK;
            if (roll < 42) return OP_POP_FRONT;
            if (roll < 64) return OP_POP_BACK;
            if (roll < 76) return OP_CONTAINS;
            if (roll < 94) return OP_REMOVE;
         end
         default: begin
            if (roll < 18) return OP_PUSH_FRONT;
            if (roll < 36) return OP_PUSH_BACK;
            if (roll < 50) return OP_POP_FRONT;
            if (roll < 64) return OP_POP_BACK;
            if (roll < 80) return OP_CONTAINS;
            if (roll < 92) return OP_REMOVE;
         end
      endcase
      return (roll[0]) ? OP_UNUSED : OP_QUERY;
   endfunction

   initial begin
      int         directed_beats;
      op_mix_type mix;
      bit         idling_on;

      for (int i = 0; i < 4; i++) word_pool[i] = fresh_word();

      // reset held from time zero, released on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: every non-push operation on an empty deque
      send_beat(OP_QUERY, '0);
      send_beat(OP_POP_FRONT, ALL_ONES);
      send_beat(OP_POP_BACK, '0);
      send_beat(OP_CONTAINS, '0);
      send_beat(OP_REMOVE, ALL_ONES);
      send_beat(OP_UNUSED, ALL_ONES);

      // --- fill to full from both ends with the two extreme words
      for (int i = 0; i < DEPTH; i++)
         send_beat(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, i[1] ? ALL_ONES : '0);

      // push onto a full deque from both ends
      send_beat(OP_PUSH_FRONT, 64'h0123_4567_89AB_CDEF);
      send_beat(OP_PUSH_BACK, 64'hFEDC_BA98_7654_3210);

      // remove all-ones (half the entries), then search both words
      send_beat(OP_REMOVE, ALL_ONES);
      send_beat(OP_CONTAINS, ALL_ONES);
      send_beat(OP_CONTAINS, '0);
      directed_beats = beats_sent;

      // --- random part
      mix       = MIX_FILL;
      idling_on = 1'b1;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 60 == 0) begin
            mix       = op_mix_type'($urandom_range(2));
            idling_on = ($urandom_range(3) != 0);
         end
         if ($urandom_range(9) == 0) word_pool[$urandom_range(3)] = fresh_word();
         if (idling_on && n < RANDOM_BEATS - QUIET_TAIL && $urandom_range(3) == 0)
            idle_gap($urandom_range(1, 5));
         send_beat(pick_opcode(mix), pick_value());
      end

      // --- drain: let the last response land, then a few quiet cycles
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d request beats (%0d directed, rest random), %0d responses checked",
               beats_sent, directed_beats, checked_count);
      $display("Deque was full on %0d pushes and empty on %0d pops or scans",
               full_hits, empty_hits);
      if (mismatch_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### deque_with_search_remove_unit.f
sv/dqsr_pkg.sv
sv/dqsr_ctrl.sv
sv/dqsr_dpath.sv
sv/deque_with_search_remove_unit.sv
verif/deque_checker.sv
verif/deque_with_search_remove_unit_tb.sv
